[rtl/core/abb_pkg.sv]
// abb_pkg: shared constants, beat types and helpers for the alpha bounding box block
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package abb_pkg;

    // frame geometry
    localparam int MAX_DIM = 4096;
    localparam int COL_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = COL_W + 1;
    localparam int ALPHA_W = 8;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0]     DIM_RESET        = DIM_W'(MAX_DIM);

    // pixel queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // result queue at the output
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    // classified pixel, front to back
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic             hit;
        logic             last;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } pix_t;

    // one finished box
    typedef struct packed {
        logic [COL_W-1:0] left;
        logic [COL_W-1:0] top;
        logic [DIM_W-1:0] right_end;
        logic [DIM_W-1:0] bottom_end;
        logic             is_empty;
        logic             is_cropped;
    } result_t;

    // zero reads as one, anything above the maximum clamps to it
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > DIM_RESET)
            begin
                r = DIM_RESET;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

[rtl/core/abb_front.sv]
// abb_front: size registers and raster counters; tags each pixel with position and frame end
// depends on abb_pkg
`timescale 1ns / 1ps

module abb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [abb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abb_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          push,
    input  logic [abb_pkg::ALPHA_W-1:0]   alpha,
    input  logic                          q_full,
    output logic                          enq,
    output abb_pkg::pix_t                 enq_item
);
    import abb_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic             row_end, frame_end;

    assign w_eff     = eff_dim(width_reg);
    assign h_eff     = eff_dim(height_reg);
    assign row_end   = ({1'b0, col_reg} + DIM_W'(1)) >= w_eff;
    assign frame_end = row_end && (({1'b0, row_reg} + DIM_W'(1)) >= h_eff);
    assign enq       = push && !q_full;

    always_comb
    begin
        enq_item.col  = col_reg;
        enq_item.row  = row_reg;
        enq_item.hit  = (alpha != '0);
        enq_item.last = frame_end;
        enq_item.w    = w_eff;
        enq_item.h    = h_eff;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (enq)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + COL_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

endmodule

[rtl/core/abb_queue.sv]
// abb_queue: short pixel queue that decouples the front from the back
// depends on abb_pkg
`timescale 1ns / 1ps

module abb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enq,
    input  abb_pkg::pix_t enq_item,
    output logic          full,
    input  logic          deq,
    output logic          valid,
    output abb_pkg::pix_t head
);
    import abb_pkg::*;

    pix_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_ptr_reg] <= enq_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/core/abb_back.sv]
// abb_back: box accumulator, result queue; one pixel/cycle, frame end stalls on full
// depends on abb_pkg
`timescale 1ns / 1ps

module abb_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  abb_pkg::pix_t             q_head,
    output logic                      q_deq,
    input  logic                      pop,
    output logic                      empty,
    output logic [abb_pkg::COL_W-1:0] left,
    output logic [abb_pkg::COL_W-1:0] top,
    output logic [abb_pkg::DIM_W-1:0] right_end,
    output logic [abb_pkg::DIM_W-1:0] bottom_end,
    output logic                      is_empty,
    output logic                      is_cropped
);
    import abb_pkg::*;

    logic [COL_W-1:0]   box_left_reg, box_top_reg;
    logic [DIM_W-1:0]   box_right_reg, box_bottom_reg;
    logic               seen_any_reg;
    logic [COL_W-1:0]   upd_left, upd_top;
    logic [DIM_W-1:0]   upd_right, upd_bottom;
    logic               upd_seen;
    logic [DIM_W-1:0]   col_end, row_end;
    result_t            res_new, res_head;
    result_t            res_mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_reg, res_rd_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic               res_full, res_push, res_pop;

    assign res_full = (res_cnt_reg == RES_CNT_W'(RES_DEPTH));
    assign q_deq    = q_valid && (!q_head.last || !res_full);
    assign res_push = q_deq && q_head.last;
    assign res_pop  = pop && !empty;
    assign empty    = (res_cnt_reg == '0);

    assign col_end = {1'b0, q_head.col} + DIM_W'(1);
    assign row_end = {1'b0, q_head.row} + DIM_W'(1);

    // fold the current pixel into the box; the first hit loads it outright
    always_comb
    begin
        upd_left   = box_left_reg;
        upd_top    = box_top_reg;
        upd_right  = box_right_reg;
        upd_bottom = box_bottom_reg;
        upd_seen   = seen_any_reg;
        if (q_head.hit)
        begin
            upd_seen = 1'b1;
            if (!seen_any_reg || q_head.col < box_left_reg)
            begin
                upd_left = q_head.col;
            end
            if (!seen_any_reg || q_head.row < box_top_reg)
            begin
                upd_top = q_head.row;
            end
            if (!seen_any_reg || col_end > box_right_reg)
            begin
                upd_right = col_end;
            end
            if (!seen_any_reg || row_end > box_bottom_reg)
            begin
                upd_bottom = row_end;
            end
        end
    end

    always_comb
    begin
        if (!upd_seen)
        begin
            res_new.left       = '0;
            res_new.top        = '0;
            res_new.right_end  = DIM_W'(1);
            res_new.bottom_end = DIM_W'(1);
            res_new.is_empty   = 1'b1;
            res_new.is_cropped = 1'b1;
        end
        else
        begin
            res_new.left       = upd_left;
            res_new.top        = upd_top;
            res_new.right_end  = upd_right;
            res_new.bottom_end = upd_bottom;
            res_new.is_empty   = 1'b0;
            res_new.is_cropped = (upd_left != '0) || (upd_top != '0) ||
                                 (upd_right < q_head.w) || (upd_bottom < q_head.h);
        end
    end

    assign res_head   = res_mem_reg[res_rd_reg];
    assign left       = res_head.left;
    assign top        = res_head.top;
    assign right_end  = res_head.right_end;
    assign bottom_end = res_head.bottom_end;
    assign is_empty   = res_head.is_empty;
    assign is_cropped = res_head.is_cropped;

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (res_push && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + RES_CNT_W'(1);
        end
        else if (res_pop && !res_push)
        begin
            res_cnt_next = res_cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg   <= '1;
            box_top_reg    <= '1;
            box_right_reg  <= '0;
            box_bottom_reg <= '0;
            seen_any_reg   <= 1'b0;
            res_wr_reg     <= '0;
            res_rd_reg     <= '0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            if (q_deq)
            begin
                if (q_head.last)
                begin
                    box_left_reg   <= '1;
                    box_top_reg    <= '1;
                    box_right_reg  <= '0;
                    box_bottom_reg <= '0;
                    seen_any_reg   <= 1'b0;
                end
                else
                begin
                    box_left_reg   <= upd_left;
                    box_top_reg    <= upd_top;
                    box_right_reg  <= upd_right;
                    box_bottom_reg <= upd_bottom;
                    seen_any_reg   <= upd_seen;
                end
            end
            if (res_push)
            begin
                res_wr_reg <= res_wr_reg + RES_PTR_W'(1);
            end
            if (res_pop)
            begin
                res_rd_reg <= res_rd_reg + RES_PTR_W'(1);
            end
            res_cnt_reg <= res_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue count out of range");

    a_frame_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (q_deq && q_head.last && !res_pop) |=> res_cnt_reg == $past(res_cnt_reg) + RES_CNT_W'(1))
        else $error("frame end did not produce a result");

    a_empty_box_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_empty) |-> (left == '0 && top == '0 &&
                                  right_end == DIM_W'(1) && bottom_end == DIM_W'(1) && is_cropped))
        else $error("empty frame result malformed");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (right_end > {1'b0, left} && bottom_end > {1'b0, top}))
        else $error("box edges out of order");
`endif

endmodule

[rtl/core/alpha_bounding_box.sv]
// alpha_bounding_box: top level; one alpha beat per cycle unless full, one box per frame
// path: a frame's last pixel beat enters the pixel queue; once the back takes it,
// behind any earlier entries, its box is written into the result queue; the back drains
// one queue entry per cycle, but holds a frame end while both result slots are taken
// reset: rst_n asynchronous active low; counters, box and queues clear, sizes return to 4096
// depends on abb_pkg, abb_front, abb_queue, abb_back
`timescale 1ns / 1ps

module alpha_bounding_box (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes, taken whenever cfg_we is high
    input  logic                          cfg_we,
    input  logic [abb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abb_pkg::CFG_DAT_W-1:0] cfg_data,
    // pixel side
    input  logic                          push,
    output logic                          full,
    input  logic [abb_pkg::ALPHA_W-1:0]   alpha,
    // box side
    output logic                          empty,
    input  logic                          pop,
    output logic [abb_pkg::COL_W-1:0]     left,
    output logic [abb_pkg::COL_W-1:0]     top,
    output logic [abb_pkg::DIM_W-1:0]     right_end,
    output logic [abb_pkg::DIM_W-1:0]     bottom_end,
    output logic                          is_empty,
    output logic                          is_cropped
);
    import abb_pkg::*;

    // front to queue
    logic enq;
    pix_t enq_item;
    logic q_full;

    // queue to back
    logic q_valid;
    logic q_deq;
    pix_t q_head;

    // full only reflects the pixel queue; the back keeps draining while a
    // finished box waits, and only stalls on a frame end with both result
    // slots taken
    assign full = q_full;

    // front: size registers, raster column/row counters, frame end detect
    abb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .alpha     (alpha),
        .q_full    (q_full),
        .enq       (enq),
        .enq_item  (enq_item)
    );

    // short queue so the front keeps taking beats while the back stalls
    abb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_item (enq_item),
        .full     (q_full),
        .deq      (q_deq),
        .valid    (q_valid),
        .head     (q_head)
    );

    // back: box min/max tracking, cropped test, result queue
    abb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_deq      (q_deq),
        .pop        (pop),
        .empty      (empty),
        .left       (left),
        .top        (top),
        .right_end  (right_end),
        .bottom_end (bottom_end),
        .is_empty   (is_empty),
        .is_cropped (is_cropped)
    );

endmodule
